>>> rtl/sap_pkg.sv
package sap_pkg;

   // Coordinate and extent widths
   localparam int COORD_BITS = 16;
   localparam int EXT_BITS = COORD_BITS + 1;
   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int PAD_BITS = 8;
   localparam int CMD_BITS = 2;
   localparam int SMEAR_STEPS = $clog2(COORD_BITS);

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = EXT_BITS;
   localparam logic [EXT_BITS-1:0] INIT_EXT_RESET = EXT_BITS'(256);

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_FIELD_BITS = 2 * COORD_BITS;
   localparam int REQ_DATA_BITS = (REQ_FIELD_BITS + 7) / 8 * 8;
   localparam int RSP_FIELD_BITS = 4 * COORD_BITS + 2 * EXT_BITS;
   localparam int RSP_DATA_BITS = (RSP_FIELD_BITS + 7) / 8 * 8;

   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
   localparam logic [EXT_BITS-1:0] EXT_MAX = {1'b1, {COORD_BITS{1'b0}}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PLACE,
      CMD_COMMIT,
      CMD_RESTART,
      CMD_NOP
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PADDING_X,
      CSR_PADDING_Y,
      CSR_INITIAL_WIDTH,
      CSR_INITIAL_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [PAD_BITS-1:0] padding_x;
      logic [PAD_BITS-1:0] padding_y;
      logic [EXT_BITS-1:0] initial_width;
      logic [EXT_BITS-1:0] initial_height;
   } cfg_type;

   typedef struct packed {
      cmd_type               command;
      logic [COORD_BITS-1:0] rect_width;
      logic [COORD_BITS-1:0] rect_height;
   } req_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] bottom;
      logic [EXT_BITS-1:0]   grow_width;
      logic [EXT_BITS-1:0]   grow_height;
      logic                  overflow;
   } rsp_item_type;

   // True when a sum does not fit a coordinate
   function automatic logic coord_over(input logic [SUM_BITS-1:0] value);
      return |value[SUM_BITS-1:COORD_BITS];
   endfunction

   // Clamp a sum to the coordinate range
   function automatic logic [COORD_BITS-1:0] coord_clamp(input logic [SUM_BITS-1:0] value);
      return coord_over(value) ? COORD_MAX : value[COORD_BITS-1:0];
   endfunction

endpackage

>>> rtl/sap_pot_round.sv
module sap_pot_round (
   input  logic [sap_pkg::SUM_BITS-1:0] pot_value,
   output logic [sap_pkg::EXT_BITS-1:0] pot_result,
   output logic                         pot_over
);
   import sap_pkg::*;

   logic [COORD_BITS-1:0] smear;
   logic                  small_value;

   // Round up to a power of two: smear the bits of value minus one, then add one
   always_comb begin
      small_value = (pot_value <= SUM_BITS'(1));
      pot_over = (pot_value > SUM_BITS'(EXT_MAX));
      smear = COORD_BITS'(pot_value - SUM_BITS'(1));
      for (int i = 0; i < SMEAR_STEPS; i++) begin
         smear = smear | (smear >> (1 << i));
      end
      if (small_value) begin
         pot_result = EXT_BITS'(1);
      end else if (pot_over) begin
         pot_result = EXT_MAX;
      end else begin
         pot_result = {1'b0, smear} + EXT_BITS'(1);
      end
   end

endmodule

>>> rtl/sap_layout.sv
module sap_layout (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  sap_pkg::cfg_type      cfg,
   input  sap_pkg::req_item_type item,
   output sap_pkg::rsp_item_type result
);
   import sap_pkg::*;

   logic [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic [COORD_BITS-1:0] row_height_ff, row_height_in;
   logic [EXT_BITS-1:0]   texture_width_ff, texture_width_in;
   logic [EXT_BITS-1:0]   texture_height_ff, texture_height_in;
   logic [EXT_BITS-1:0]   pending_width_ff, pending_width_in;
   logic [EXT_BITS-1:0]   pending_height_ff, pending_height_in;

   logic                  have_pending;
   logic [EXT_BITS-1:0]   cur_w;
   logic [EXT_BITS-1:0]   cur_h;
   logic [SUM_BITS-1:0]   req_w;
   logic [SUM_BITS-1:0]   req_h;
   logic                  wrap;
   logic [SUM_BITS-1:0]   wrap_y;
   logic [COORD_BITS-1:0] place_x;
   logic [COORD_BITS-1:0] place_y;
   logic [COORD_BITS-1:0] place_rh;
   logic                  grow_w;
   logic                  grow_h;
   logic [SUM_BITS-1:0]   right_sum;
   logic [SUM_BITS-1:0]   bottom_sum;
   logic [SUM_BITS-1:0]   next_x_sum;
   logic [SUM_BITS-1:0]   pot_w_value;
   logic [SUM_BITS-1:0]   pot_h_value;
   logic [EXT_BITS-1:0]   pot_w;
   logic [EXT_BITS-1:0]   pot_h;
   logic                  pot_w_over;
   logic                  pot_h_over;

   // Shelf position seen by this placement, after a possible row wrap
   always_comb begin
      have_pending = (pending_width_ff != '0);
      cur_w = have_pending ? pending_width_ff : texture_width_ff;
      cur_h = have_pending ? pending_height_ff : texture_height_ff;
      req_w = SUM_BITS'(item.rect_width) + SUM_BITS'(cfg.padding_x);
      req_h = SUM_BITS'(item.rect_height) + SUM_BITS'(cfg.padding_y);
      wrap = (SUM_BITS'(cursor_x_ff) + req_w) > SUM_BITS'(texture_width_ff);
      wrap_y = SUM_BITS'(cursor_y_ff) + SUM_BITS'(row_height_ff)
               + SUM_BITS'(cfg.padding_y);
      place_x = wrap ? COORD_BITS'(cfg.padding_x) : cursor_x_ff;
      place_y = wrap ? coord_clamp(wrap_y) : cursor_y_ff;
      place_rh = wrap ? '0 : row_height_ff;
      grow_w = (SUM_BITS'(place_x) + req_w) > SUM_BITS'(cur_w);
      grow_h = (SUM_BITS'(place_y) + req_h) > SUM_BITS'(cur_h);
      pot_w_value = SUM_BITS'(item.rect_width);
      pot_h_value = SUM_BITS'(cur_h) + req_h;
      right_sum = SUM_BITS'(place_x) + SUM_BITS'(item.rect_width);
      bottom_sum = SUM_BITS'(place_y) + SUM_BITS'(item.rect_height);
      next_x_sum = SUM_BITS'(place_x) + req_w;
   end

   // Grown extent candidates
   sap_pot_round u_pot_w (
      .pot_value  (pot_w_value),
      .pot_result (pot_w),
      .pot_over   (pot_w_over)
   );

   sap_pot_round u_pot_h (
      .pot_value  (pot_h_value),
      .pot_result (pot_h),
      .pot_over   (pot_h_over)
   );

   // Command decode: next layout state and the result transaction
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      row_height_in = row_height_ff;
      texture_width_in = texture_width_ff;
      texture_height_in = texture_height_ff;
      pending_width_in = pending_width_ff;
      pending_height_in = pending_height_ff;
      result = '0;
      case (item.command)
         CMD_PLACE: begin
            if (grow_w || grow_h) begin
               pending_width_in = grow_w ? pot_w : cur_w;
               pending_height_in = grow_h ? pot_h : cur_h;
            end
            cursor_x_in = coord_clamp(next_x_sum);
            cursor_y_in = place_y;
            row_height_in = (req_h > SUM_BITS'(place_rh)) ? coord_clamp(req_h) : place_rh;
            result.left = place_x;
            result.top = place_y;
            result.right = coord_clamp(right_sum);
            result.bottom = coord_clamp(bottom_sum);
            result.overflow = (wrap && coord_over(wrap_y))
                              || (grow_w && pot_w_over)
                              || (grow_h && pot_h_over)
                              || coord_over(right_sum)
                              || coord_over(bottom_sum)
                              || coord_over(next_x_sum)
                              || coord_over(req_h);
         end
         CMD_COMMIT: begin
            if (have_pending) begin
               texture_width_in = pending_width_ff;
               texture_height_in = pending_height_ff;
               pending_width_in = '0;
               pending_height_in = '0;
            end
         end
         CMD_RESTART: begin
            texture_width_in = cfg.initial_width;
            texture_height_in = cfg.initial_height;
            cursor_x_in = COORD_BITS'(cfg.padding_x);
            cursor_y_in = COORD_BITS'(cfg.padding_y);
            row_height_in = '0;
            pending_width_in = '0;
            pending_height_in = '0;
         end
         default: begin
         end
      endcase
      result.grow_width = pending_width_in;
      result.grow_height = pending_height_in;
   end

   // Hold layout state, advance on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         row_height_ff <= '0;
         texture_width_ff <= INIT_EXT_RESET;
         texture_height_ff <= INIT_EXT_RESET;
         pending_width_ff <= '0;
         pending_height_ff <= '0;
      end else if (step_en) begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         row_height_ff <= row_height_in;
         texture_width_ff <= texture_width_in;
         texture_height_ff <= texture_height_in;
         pending_width_ff <= pending_width_in;
         pending_height_ff <= pending_height_in;
      end
   end

endmodule

>>> rtl/shelf_atlas_packer_top.sv
// Shelf packer for a texture atlas. Each request transaction carries a command in
// req_tuser (place, commit pending extent, restart layout, no operation) and a
// rectangle size in req_tdata; each one yields exactly one response transaction
// with the placed rectangle, the pending grown extent (zero when none) and an
// overflow flag. Throughput is one transaction per clock. A request accepted on
// req_tready is held in a request register, passes a combinational layout update
// whose cursor, row and extent registers close their loop, and then sits in the
// response register that drives rsp_tvalid. Backpressure on rsp_tready stalls
// both stages. Write configuration registers only while the block is idle.
module shelf_atlas_packer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sap_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // rect_width, rect_height
   input  logic [sap_pkg::CMD_BITS-1:0]         req_tuser,  // command
   // Response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left, top, right, bottom, grow_width, grow_height, zero fill
   output logic [sap_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                 rsp_tuser,  // overflow
   // Configuration write port
   input  logic                                 csr_we,
   input  logic [sap_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sap_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import sap_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   logic         advance;
   logic         step_en;
   logic         req_take;

   // Handshake: request stage moves whenever the response register frees up
   assign advance = !out_valid_ff || rsp_tready;
   assign step_en = in_valid_ff && advance;
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign req_take = req_tvalid && req_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.padding_x <= '0;
         cfg_ff.padding_y <= '0;
         cfg_ff.initial_width <= INIT_EXT_RESET;
         cfg_ff.initial_height <= INIT_EXT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PADDING_X:      cfg_ff.padding_x <= csr_wdata[PAD_BITS-1:0];
            CSR_PADDING_Y:      cfg_ff.padding_y <= csr_wdata[PAD_BITS-1:0];
            CSR_INITIAL_WIDTH:  cfg_ff.initial_width <= csr_wdata;
            CSR_INITIAL_HEIGHT: cfg_ff.initial_height <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command <= cmd_type'(req_tuser);
         in_item_ff.rect_width <= req_tdata[COORD_BITS-1:0];
         in_item_ff.rect_height <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      end
   end

   sap_layout u_layout (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cfg     (cfg_ff),
      .item    (in_item_ff),
      .result  (step_result)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_item_ff.overflow;
   assign rsp_tdata = RSP_DATA_BITS'({out_item_ff.grow_height, out_item_ff.grow_width,
                                      out_item_ff.bottom, out_item_ff.right,
                                      out_item_ff.top, out_item_ff.left});

endmodule

>>> rtl/sap_checker.sv
module sap_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [sap_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import sap_pkg::*;

   // No response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Hold a stalled response transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A new response follows a request taken earlier
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without matching request");

   // Placed edges never precede their origin
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2*COORD_BITS +: COORD_BITS] >= rsp_tdata[0 +: COORD_BITS])
                     && (rsp_tdata[3*COORD_BITS +: COORD_BITS]
                         >= rsp_tdata[COORD_BITS +: COORD_BITS]))
      else $error("right or bottom edge below origin");

endmodule

bind shelf_atlas_packer_top sap_checker u_sap_checker (.*);

>>> tb/tb_shelf_atlas_packer_top.sv
`timescale 1ns / 100ps

module tb_shelf_atlas_packer_top;
   import sap_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int EB = EXT_BITS;
   localparam int PB = PAD_BITS;
   localparam longint unsigned COORD_TOP = (64'd1 << CB) - 64'd1;
   localparam longint unsigned EXT_TOP = 64'd1 << CB;
   localparam int CYCLE_LIMIT = 400000;

   // Shelf layout tracker: mirrors cursor, shelf and extent state and queues
   // the response each accepted request should produce
   class layout_tracker;
      bit [PB-1:0]  pad_x, pad_y;
      bit [EB-1:0]  init_w, init_h;
      bit [EB-1:0]  tex_w, tex_h, pend_w, pend_h;
      bit [CB-1:0]  cur_x, cur_y, shelf_h;
      rsp_item_type expected_rects[$];
      int           errors;

      function new();
         pad_x = '0;
         pad_y = '0;
         init_w = INIT_EXT_RESET;
         init_h = INIT_EXT_RESET;
         tex_w = INIT_EXT_RESET;
         tex_h = INIT_EXT_RESET;
         pend_w = '0;
         pend_h = '0;
         cur_x = '0;
         cur_y = '0;
         shelf_h = '0;
         errors = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_PADDING_X:      pad_x = value[PB-1:0];
            CSR_PADDING_Y:      pad_y = value[PB-1:0];
            CSR_INITIAL_WIDTH:  init_w = value;
            CSR_INITIAL_HEIGHT: init_h = value;
            default: ;
         endcase
      endfunction

      // Clamp a sum to the coordinate range, flag saturation
      function longint unsigned clamp_coord(input longint unsigned v, inout bit ovf);
         if (v > COORD_TOP) begin
            ovf = 1'b1;
            return COORD_TOP;
         end
         return v;
      endfunction

      // Round up to a power of two, clamped to the largest extent
      function longint unsigned pow2_ceil(input longint unsigned v, inout bit ovf);
         longint unsigned r;
         r = 1;
         while (r < v && r < EXT_TOP) r = r << 1;
         if (r < v) begin
            ovf = 1'b1;
            r = EXT_TOP;
         end
         return r;
      endfunction

      // Advance the layout by one command and build its response
      function rsp_item_type place_step(cmd_type cmd, logic [CB-1:0] w_in,
                                        logic [CB-1:0] h_in);
         rsp_item_type    res;
         longint unsigned w, h, x, y, row, need_w, need_h, span_w, span_h;
         bit              ovf, growing, stretch_w, stretch_h;
         res = '0;
         ovf = 1'b0;
         w = w_in;
         h = h_in;
         x = cur_x;
         y = cur_y;
         row = shelf_h;
         case (cmd)
            CMD_PLACE: begin
               growing = pend_w != 0;
               span_w = growing ? pend_w : tex_w;
               span_h = growing ? pend_h : tex_h;
               need_w = w + pad_x;
               need_h = h + pad_y;
               // wrap to a new shelf when the committed width is overrun
               if (x + need_w > tex_w) begin
                  y = clamp_coord(y + row + pad_y, ovf);
                  x = pad_x;
                  row = 0;
               end
               stretch_w = x + need_w > span_w;
               stretch_h = y + need_h > span_h;
               if (stretch_w || stretch_h) begin
                  pend_w = EB'(stretch_w ? pow2_ceil(w, ovf) : span_w);
                  pend_h = EB'(stretch_h ? pow2_ceil(span_h + need_h, ovf) : span_h);
               end
               res.left = CB'(x);
               res.top = CB'(y);
               res.right = CB'(clamp_coord(x + w, ovf));
               res.bottom = CB'(clamp_coord(y + h, ovf));
               x = clamp_coord(x + need_w, ovf);
               if (need_h > row) row = clamp_coord(need_h, ovf);
            end
            CMD_COMMIT: begin
               if (pend_w != 0) begin
                  tex_w = pend_w;
                  tex_h = pend_h;
                  pend_w = '0;
                  pend_h = '0;
               end
            end
            CMD_RESTART: begin
               tex_w = init_w;
               tex_h = init_h;
               x = pad_x;
               y = pad_y;
               row = 0;
               pend_w = '0;
               pend_h = '0;
            end
            default: ;
         endcase
         cur_x = CB'(x);
         cur_y = CB'(y);
         shelf_h = CB'(row);
         res.grow_width = pend_w;
         res.grow_height = pend_h;
         res.overflow = ovf;
         return res;
      endfunction

      function void note_request(cmd_type cmd, logic [CB-1:0] w, logic [CB-1:0] h);
         expected_rects.insert(expected_rects.size(), place_step(cmd, w, h));
      endfunction

      function void report(string name, logic [EB-1:0] want, logic [EB-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      // Compare one response transaction with the oldest expectation
      function void check_response(logic [RSP_DATA_BITS-1:0] data, logic user);
         rsp_item_type want;
         if (expected_rects.size() == 0) begin
            errors++;
            $display("%0t: response with no request waiting, actual data %h", $time, data);
            return;
         end
         want = expected_rects.pop_front();
         report("left", EB'(want.left), EB'(data[0 +: CB]));
         report("top", EB'(want.top), EB'(data[CB +: CB]));
         report("right", EB'(want.right), EB'(data[2*CB +: CB]));
         report("bottom", EB'(want.bottom), EB'(data[3*CB +: CB]));
         report("grow_width", want.grow_width, data[4*CB +: EB]);
         report("grow_height", want.grow_height, data[4*CB+EB +: EB]);
         report("overflow", EB'(want.overflow), EB'(user));
      endfunction

      function int outstanding();
         return expected_rects.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata;   // rect_width, rect_height
   logic [CMD_BITS-1:0]        req_tuser;   // command
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;   // left, top, right, bottom, grow_width, grow_height
   logic                       rsp_tuser;   // overflow
   logic                       csr_we;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   layout_tracker tracker = new();
   bit            req_fire;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            cycles = 0;

   shelf_atlas_packer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample both channels; check responses before noting the new request
   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tuser);
         req_fire = req_tvalid && req_tready;
         if (req_fire)
            tracker.note_request(cmd_type'(req_tuser), req_tdata[0 +: CB], req_tdata[CB +: CB]);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, tracker.outstanding());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Random backpressure on the response channel
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   // Drive one request transaction, idling the sender at random first
   task automatic send_item(cmd_type cmd, logic [CB-1:0] w, logic [CB-1:0] h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {h, w};
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(int px, int py, int iw, int ih);
      csr_write(CSR_PADDING_X, CSR_DATA_BITS'(px));
      csr_write(CSR_PADDING_Y, CSR_DATA_BITS'(py));
      csr_write(CSR_INITIAL_WIDTH, CSR_DATA_BITS'(iw));
      csr_write(CSR_INITIAL_HEIGHT, CSR_DATA_BITS'(ih));
   endtask

   // Hold the sender idle until every response has come back
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
   endtask

   // Mostly small sides so shelves fill; some wide, full-range and extreme
   function automatic logic [CB-1:0] rand_side();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return CB'($urandom_range(40));
      if (pick < 88) return CB'($urandom_range(600));
      if (pick < 97) return CB'($urandom);
      return $urandom_range(1) ? '1 : '0;
   endfunction

   task automatic send_random();
      int      pick;
      cmd_type cmd;
      pick = $urandom_range(99);
      if (pick < 82) cmd = CMD_PLACE;
      else if (pick < 90) cmd = CMD_COMMIT;
      else if (pick < 94) cmd = CMD_RESTART;
      else cmd = CMD_NOP;
      send_item(cmd, rand_side(), rand_side());
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      send_item(CMD_RESTART, '0, '0);
      repeat (count) send_random();
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_NOP;
      csr_we = 1'b0;
      csr_index = CSR_PADDING_X;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: reset configuration, empty and huge rectangles, wrap,
      // growth with saturation, commit with and without a pending extent
      send_item(CMD_PLACE, '0, '0);
      send_item(CMD_PLACE, 16, 16);
      send_item(CMD_PLACE, 300, 10);
      send_item(CMD_PLACE, '1, '1);
      send_item(CMD_COMMIT, '0, '0);
      send_item(CMD_COMMIT, '1, '1);
      send_item(CMD_NOP, '1, '0);
      send_item(CMD_PLACE, '1, '0);
      send_item(CMD_RESTART, '0, '1);
      send_item(CMD_PLACE, 256, 256);
      send_item(CMD_PLACE, 1, 1);
      wait_drained();

      // Directed: wide padding, smallest and largest initial extents
      set_config(7, 255, 1, 65536);
      send_item(CMD_RESTART, '0, '0);
      send_item(CMD_PLACE, '0, '0);
      send_item(CMD_PLACE, '1, '1);
      send_item(CMD_PLACE, 1, 1);
      send_item(CMD_COMMIT, '0, '0);
      send_item(CMD_PLACE, 255, 255);
      send_item(CMD_NOP, '0, '0);
      send_item(CMD_RESTART, '1, '1);
      send_item(CMD_PLACE, 0, 65535);
      wait_drained();

      // Random phases with varying configuration and idling
      set_config(255, 255, 65536, 65536);
      run_phase(0, 0, 175);
      set_config(0, 0, 1, 1);
      run_phase(52, 0, 175);
      set_config($urandom_range(15), $urandom_range(15),
                 $urandom_range(1, 4096), $urandom_range(1, 4096));
      run_phase(0, 52, 175);
      set_config($urandom_range(255), $urandom_range(255),
                 $urandom_range(1, 65536), $urandom_range(1, 65536));
      run_phase(15, 15, 175);

      // Let any stray response show up
      repeat (6) @(negedge clock);
      if (tracker.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
